>>> hdl/cza_pkg.sv
// ----------------------------------------------------------------------------
// cza_pkg: shared types and constants for the COBS ZPE/ZRE decoder
// Event codes, sequencer states, the result record and the code-byte
// constants of the zero-pair and zero-run extended COBS format.
// ----------------------------------------------------------------------------
package cza_pkg;

    localparam int COUNT_BITS_DEF = 13;
    localparam int CAP_W          = 13;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 12;
    localparam int ZCNT_W         = 4;

    localparam logic [CAP_W-1:0]  CAP_RESET = 13'd4096;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 12'd4095;

    // code byte boundaries and masks
    localparam logic [BYTE_W-1:0] CODE_FULL    = 8'hD2;
    localparam logic [BYTE_W-1:0] CODE_RUN_LO  = 8'hD3;
    localparam logic [BYTE_W-1:0] CODE_RUN_HI  = 8'hDF;
    localparam logic [BYTE_W-1:0] CODE_PAIR_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_RUN     = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_PAIR    = 8'h1F;
    localparam logic [BYTE_W-1:0] DELIM        = 8'h00;

    typedef enum logic [2:0] {
        EVT_BYTE    = 3'd0,
        EVT_GOOD    = 3'd1,
        EVT_EMPTY   = 3'd2,
        EVT_BROKEN  = 3'd3,
        EVT_OVERRUN = 3'd4
    } evt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_DECODE,
        ST_ZFIT,
        ST_ZERO,
        ST_FIN
    } seq_st_t;

    typedef struct packed {
        evt_t              kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              last;
    } res_t;

endpackage

>>> hdl/cza_fit.sv
// ----------------------------------------------------------------------------
// cza_fit: frame capacity check unit
// Shared add-and-compare: tells whether the frame count plus the bytes
// about to be added stays below the clamped frame capacity.
// ----------------------------------------------------------------------------
module cza_fit #(
    parameter int COUNT_BITS = cza_pkg::COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0]      count,
    input  logic [cza_pkg::ZCNT_W-1:0] added,
    input  logic [cza_pkg::CAP_W-1:0]  cap,
    output logic                       fits
);
    import cza_pkg::*;

    localparam int CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << COUNT_BITS;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;
    logic [CMP_W-1:0] sum;

    always_comb begin
        cap_ext = CMP_W'(cap);
        cap_eff = (cap_ext < LIMIT) ? cap_ext : LIMIT;
        sum     = CMP_W'(count) + CMP_W'(added);
        fits    = (sum < cap_eff);
    end

endmodule

>>> hdl/cza_seq.sv
// ----------------------------------------------------------------------------
// cza_seq: decode sequencer
// Walks one received byte through capacity check, decode, zero fill and
// finish, one result per cycle while the output is not stalled, holding the
// newest result so the last one can be marked.
// ----------------------------------------------------------------------------
module cza_seq #(
    parameter int COUNT_BITS = cza_pkg::COUNT_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cza_pkg::BYTE_W-1:0] in_byte,
    output logic [COUNT_BITS-1:0]      fit_count,
    output logic [cza_pkg::ZCNT_W-1:0] fit_added,
    input  logic                       fit_ok,
    output logic                       push_valid,
    input  logic                       push_ready,
    output cza_pkg::res_t              push_res
);
    import cza_pkg::*;

    localparam int LW = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    seq_st_t             st_reg, st_next;
    logic                phase_reg, phase_next;
    logic [BYTE_W-1:0]   data_left_reg, data_left_next;
    logic [ZCNT_W-1:0]   zeros_left_reg, zeros_left_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0]   held_byte_reg, held_byte_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                pend_valid_reg, pend_valid_next;
    res_t                pend_reg, pend_next;

    logic                want_emit;
    logic                stall;
    res_t                new_res;
    logic [ZCNT_W-1:0]   code_zeros;
    logic [BYTE_W-1:0]   code_data;
    logic [LW-1:0]       len_ext;
    logic [LEN_W-1:0]    len_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            phase_reg      <= 1'b0;
            data_left_reg  <= '0;
            zeros_left_reg <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            st_reg         <= st_next;
            phase_reg      <= phase_next;
            data_left_reg  <= data_left_next;
            zeros_left_reg <= zeros_left_next;
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        pend_reg <= pend_next;
    end

    // code byte decode
    always_comb begin
        if (byte_reg == CODE_FULL) begin
            code_zeros = '0;
            code_data  = byte_reg - 8'd1;
        end else if (byte_reg >= CODE_RUN_LO && byte_reg <= CODE_RUN_HI) begin
            code_zeros = ZCNT_W'(byte_reg & MASK_RUN);
            code_data  = '0;
        end else if (byte_reg >= CODE_PAIR_LO) begin
            code_zeros = ZCNT_W'(2);
            code_data  = byte_reg & MASK_PAIR;
        end else begin
            code_zeros = ZCNT_W'(1);
            code_data  = byte_reg - 8'd1;
        end
    end

    // good frame length: count minus the phantom byte, saturated
    always_comb begin
        len_ext = LW'(count_reg) - LW'(1);
        len_sat = (len_ext > LW'(LEN_MAX)) ? LEN_MAX : len_ext[LEN_W-1:0];
    end

    assign in_ready  = (st_reg == ST_IDLE);
    assign fit_count = count_reg;
    assign fit_added = (st_reg == ST_ZFIT) ? zeros_left_reg : ZCNT_W'(1);
    assign stall     = pend_valid_reg && !push_ready;

    always_comb begin
        st_next         = st_reg;
        phase_next      = phase_reg;
        data_left_next  = data_left_reg;
        zeros_left_next = zeros_left_reg;
        count_next      = count_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        byte_next       = byte_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        want_emit       = 1'b0;
        new_res         = '{kind: EVT_BYTE, data: '0, len: '0, last: 1'b0};
        push_valid      = 1'b0;
        push_res        = pend_reg;
        push_res.last   = 1'b0;

        case (st_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    byte_next = in_byte;
                    st_next   = ST_CHK;
                end
            end
            ST_CHK: begin
                if (!fit_ok) begin
                    want_emit    = 1'b1;
                    new_res.kind = EVT_OVERRUN;
                    if (!stall) begin
                        count_next      = '0;
                        held_valid_next = 1'b0;
                        held_byte_next  = '0;
                        phase_next      = 1'b0;
                        st_next         = ST_DECODE;
                    end
                end else begin
                    st_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (byte_reg != DELIM && !phase_reg) begin
                    phase_next      = 1'b1;
                    zeros_left_next = code_zeros;
                    data_left_next  = code_data;
                    st_next         = (code_data == '0) ? ST_ZFIT : ST_FIN;
                end else if (byte_reg != DELIM) begin
                    want_emit    = held_valid_reg;
                    new_res.data = held_byte_reg;
                    if (!(want_emit && stall)) begin
                        data_left_next  = data_left_reg - 8'd1;
                        held_byte_next  = byte_reg;
                        held_valid_next = 1'b1;
                        count_next      = count_reg + COUNT_BITS'(1);
                        st_next = (data_left_reg == 8'd1) ? ST_ZFIT : ST_FIN;
                    end
                end else begin
                    want_emit = 1'b1;
                    if (phase_reg) begin
                        new_res.kind = EVT_BROKEN;
                    end else if (count_reg != '0) begin
                        new_res.kind = EVT_GOOD;
                        new_res.len  = len_sat;
                    end else begin
                        new_res.kind = EVT_EMPTY;
                    end
                    if (!stall) begin
                        count_next      = '0;
                        held_valid_next = 1'b0;
                        held_byte_next  = '0;
                        phase_next      = 1'b0;
                        st_next         = ST_FIN;
                    end
                end
            end
            ST_ZFIT: begin
                if (fit_ok) begin
                    if (zeros_left_reg == '0) begin
                        phase_next = 1'b0;
                        st_next    = ST_FIN;
                    end else begin
                        st_next = ST_ZERO;
                    end
                end else begin
                    want_emit    = 1'b1;
                    new_res.kind = EVT_OVERRUN;
                    if (!stall) begin
                        count_next      = '0;
                        held_valid_next = 1'b0;
                        held_byte_next  = '0;
                        phase_next      = 1'b0;
                        st_next         = ST_FIN;
                    end
                end
            end
            ST_ZERO: begin
                want_emit    = held_valid_reg;
                new_res.data = held_byte_reg;
                if (!(want_emit && stall)) begin
                    held_byte_next  = '0;
                    held_valid_next = 1'b1;
                    count_next      = count_reg + COUNT_BITS'(1);
                    zeros_left_next = zeros_left_reg - ZCNT_W'(1);
                    if (zeros_left_reg == ZCNT_W'(1)) begin
                        phase_next = 1'b0;
                        st_next    = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // flush the held-back result, marked as the last one
                if (pend_valid_reg) begin
                    push_valid    = 1'b1;
                    push_res.last = 1'b1;
                    if (push_ready) begin
                        pend_valid_next = 1'b0;
                        st_next         = ST_IDLE;
                    end
                end else begin
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        // a new result pushes the previous one out and takes its place
        if (want_emit) begin
            push_valid = pend_valid_reg;
            if (!stall) begin
                pend_next       = new_res;
                pend_valid_next = 1'b1;
            end
        end
    end

endmodule

>>> hdl/cobs_zpe_zre_decoder_core.sv
// ----------------------------------------------------------------------------
// cobs_zpe_zre_decoder_core: COBS decoder with zero-pair and zero-run codes
// Takes one encoded byte per transfer and streams out decoded bytes and
// frame events (good frame with length, empty, broken, overrun).
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_in_byte
//  m_        out        m_valid / m_ready    m_event_kind, m_out_byte,
//                                            m_frame_length, m_last
//  cfg_      in         cfg_valid/cfg_ready  cfg_data (frame capacity)
//
//  One byte passes from its transfer to the next s_ready through check,
//  decode, finish and idle, plus a zero fill check when the data of a
//  block runs out and one zero state per implicit zero (up to 15). The
//  sequencer in cza_seq steps through these states and uses the shared
//  capacity check unit. Each decoded byte is released one byte late, so
//  the phantom zero at a good frame end is dropped. Reset is synchronous
//  and active low; the capacity resets to 4096. A stall on m_ready holds
//  the sequencer in place once two results are waiting.
//
module cobs_zpe_zre_decoder_core #(
    parameter int COUNT_BITS = cza_pkg::COUNT_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [cza_pkg::BYTE_W-1:0] s_in_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_event_kind,
    output logic [cza_pkg::BYTE_W-1:0] m_out_byte,
    output logic [cza_pkg::LEN_W-1:0]  m_frame_length,
    output logic                       m_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cza_pkg::CAP_W-1:0]  cfg_data
);
    import cza_pkg::*;

    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic                  m_valid_reg, m_valid_next;
    res_t                  m_res_reg, m_res_next;

    logic [COUNT_BITS-1:0] fit_count;
    logic [ZCNT_W-1:0]     fit_added;
    logic                  fit_ok;
    logic                  push_valid;
    logic                  push_ready;
    res_t                  push_res;

    // capacity register: writes land only while the block is idle
    assign cfg_ready = s_ready;

    always_comb begin
        cap_next = cap_reg;
        if (cfg_valid && cfg_ready) begin
            cap_next = cfg_data;
        end
    end

    // output register: take a new result when empty or being drained
    assign push_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (push_ready) begin
            m_valid_next = push_valid;
            if (push_valid) begin
                m_res_next = push_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = m_res_reg.kind;
    assign m_out_byte     = m_res_reg.data;
    assign m_frame_length = m_res_reg.len;
    assign m_last         = m_res_reg.last;

    cza_fit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fit (
        .count (fit_count),
        .added (fit_added),
        .cap   (cap_reg),
        .fits  (fit_ok)
    );

    cza_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_in_byte),
        .fit_count  (fit_count),
        .fit_added  (fit_added),
        .fit_ok     (fit_ok),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_res   (push_res)
    );

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for cobs_zpe_zre_decoder_core
// Sends encoded bytes through the valid/ready input channel and checks every
// decoded byte and frame event against an in-bench decoder model or a
// typed-in expectation. The run opens with a short directed table, then
// sends random frames under a series of frame capacities. A long output
// stall during the directed table backs up the input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cza_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_MAX     = 13;
    // drain margin for one byte's walk: check, decode, a zero fill check, up to 15 zeros, finish
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 2;
    localparam int MAX_RESULTS  = 16;
    localparam logic [CAP_W-1:0] CAP_TOP = 13'd8191;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [BYTE_W-1:0]       s_in_byte;
    logic                    m_valid;
    logic                    m_ready;
    logic [2:0]              m_event_kind;
    logic [BYTE_W-1:0]       m_out_byte;
    logic [LEN_W-1:0]        m_frame_length;
    logic                    m_last;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CAP_W-1:0]        cfg_data;

    cobs_zpe_zre_decoder_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_out_byte     (m_out_byte),
        .m_frame_length (m_frame_length),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Decoder model: capacity, parser state and the decoded byte held back
    // by one step so the phantom zero of a good frame can be dropped.
    // ------------------------------------------------------------------------
    logic [CAP_W-1:0]          capacity;
    logic                      awaiting_data;
    logic [7:0]                data_left;
    logic [ZCNT_W-1:0]         zeros_left;
    logic [COUNT_BITS_DEF-1:0] frame_cnt;
    logic                      held_v;
    logic [BYTE_W-1:0]         held_b;

    res_t step_results[$];      // results of the byte being decoded
    res_t pending_results[$];   // results still owed by the block

    // directed rows may carry a typed-in expectation instead of the model's
    logic row_typed;
    res_t row_want;

    // receiver and sender idling controls
    bit tx_quiet;
    bit rx_quiet;
    bit hold_req;

    int n_err;
    int n_sent;
    int n_res;
    int n_caps;
    int n_cycles;
    int n_in_stall;
    int kind_cnt [5];

    function automatic void note(evt_t k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l);
        res_t r;
        if (step_results.size() >= MAX_RESULTS)
            return;
        r.kind = k;
        r.data = d;
        r.len  = l;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void drop_frame();
        frame_cnt     = '0;
        held_v        = 1'b0;
        held_b        = '0;
        awaiting_data = 1'b0;
    endfunction

    // Check that the frame can take more bytes; drop it and flag overrun if not.
    function automatic bit has_room(int added);
        if (int'(frame_cnt) + added < int'(capacity))
            return 1'b1;
        drop_frame();
        note(EVT_OVERRUN, '0, '0);
        return 1'b0;
    endfunction

    // Release the held byte and hold back the new one.
    function automatic void push_decoded(logic [BYTE_W-1:0] b);
        if (held_v)
            note(EVT_BYTE, held_b, '0);
        held_b    = b;
        held_v    = 1'b1;
        frame_cnt = frame_cnt + 1'b1;
    endfunction

    function automatic void fill_zeros();
        if (!has_room(int'(zeros_left)))
            return;
        while (zeros_left != 0) begin
            push_decoded('0);
            zeros_left = zeros_left - 1'b1;
        end
        awaiting_data = 1'b0;
    endfunction

    function automatic void decode_step(logic [BYTE_W-1:0] b);
        logic [COUNT_BITS_DEF-1:0] len_full;
        step_results.delete();
        void'(has_room(1));
        if (b != DELIM && !awaiting_data) begin
            awaiting_data = 1'b1;
            if (b == CODE_FULL) begin
                zeros_left = '0;
                data_left  = b - 8'd1;
            end else if (b >= CODE_RUN_LO && b <= CODE_RUN_HI) begin
                zeros_left = ZCNT_W'(b & MASK_RUN);
                data_left  = '0;
            end else if (b >= CODE_PAIR_LO) begin
                zeros_left = 4'd2;
                data_left  = b & MASK_PAIR;
            end else begin
                zeros_left = 4'd1;
                data_left  = b - 8'd1;
            end
            if (data_left == 0)
                fill_zeros();
        end else if (b != DELIM) begin
            data_left = data_left - 8'd1;
            push_decoded(b);
            if (data_left == 0)
                fill_zeros();
        end else begin
            if (!awaiting_data && frame_cnt != 0) begin
                // drop the phantom zero and saturate the length
                len_full = frame_cnt - 1'b1;
                note(EVT_GOOD, '0, (len_full > LEN_MAX) ? LEN_MAX : LEN_W'(len_full));
            end else if (!awaiting_data) begin
                note(EVT_EMPTY, '0, '0);
            end else begin
                note(EVT_BROKEN, '0, '0);
            end
            drop_frame();
        end
        if (step_results.size() != 0)
            step_results[step_results.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: track config writes, decode each accepted byte into the list
    // of owed results, and compare every result transfer with the oldest one.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        res_t want;
        if (!aresetn) begin
            capacity      = CAP_RESET;
            data_left     = '0;
            zeros_left    = '0;
            drop_frame();
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (s_valid && !s_ready)
                n_in_stall++;
            if (s_valid && s_ready) begin
                decode_step(s_in_byte);
                if (row_typed) begin
                    pending_results.push_back(row_want);
                end else begin
                    foreach (step_results[i])
                        pending_results.push_back(step_results[i]);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d byte %0h length %0d last %0b",
                           m_event_kind, m_out_byte, m_frame_length, m_last);
                    n_err++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_event_kind !== want.kind) begin
                        $error("m_event_kind: expected %0d, got %0d", want.kind, m_event_kind);
                        n_err++;
                    end
                    if (m_out_byte !== want.data) begin
                        $error("m_out_byte: expected %0h, got %0h", want.data, m_out_byte);
                        n_err++;
                    end
                    if (m_frame_length !== want.len) begin
                        $error("m_frame_length: expected %0d, got %0d",
                               want.len, m_frame_length);
                        n_err++;
                    end
                    if (m_last !== want.last) begin
                        $error("m_last: expected %0b, got %0b", want.last, m_last);
                        n_err++;
                    end
                    if (int'(want.kind) < 5)
                        kind_cnt[int'(want.kind)]++;
                    n_res++;
                end
            end
        end
    end

    // Give up after a generous number of cycles.
    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results still owed",
                   n_cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall a random number of cycles before each result, none in
    // quiet stretches, and once a long hold-off so the block backs up.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                n = rx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Offer one byte after a random gap and hold it until the transfer.
    task automatic send_byte(logic [BYTE_W-1:0] b, bit typed = 1'b0, res_t want = '0);
        int gap;
        @(negedge aclk);
        gap = tx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        row_typed = typed;
        row_want  = want;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // Let the block drain and settle, then write the frame capacity.
    task automatic write_capacity(logic [CAP_W-1:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        n_caps++;
    endtask

    // Mostly well-formed frames with random content, some noise codes, some
    // frames cut short by a delimiter, and now and then an empty frame.
    task automatic send_frame();
        int nblk;
        int sel;
        int ndata;
        logic [BYTE_W-1:0] code;
        bit cut;
        nblk = $urandom_range(1, 4);
        cut  = 1'b0;
        for (int k = 0; k < nblk && !cut; k++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 3: begin
                    code  = 8'($urandom_range(1, 12));
                    ndata = int'(code) - 1;
                end
                4, 5: begin
                    code  = CODE_PAIR_LO | 8'($urandom_range(0, 31));
                    ndata = int'(code & MASK_PAIR);
                end
                6, 7: begin
                    code  = 8'($urandom_range(CODE_RUN_LO, CODE_RUN_HI));
                    ndata = 0;
                end
                8: begin
                    code  = 8'($urandom_range(0, 255));
                    ndata = 0;
                end
                default: begin
                    code  = 8'($urandom_range(13, 64));
                    ndata = int'(code) - 1;
                end
            endcase
            send_byte(code);
            for (int j = 0; j < ndata && !cut; j++) begin
                if ($urandom_range(0, 40) == 0) begin
                    send_byte(DELIM);
                    cut = 1'b1;
                end else begin
                    send_byte(8'($urandom_range(1, 255)));
                end
            end
        end
        if (!cut)
            send_byte(DELIM);
        if ($urandom_range(0, 5) == 0)
            send_byte(DELIM);
    endtask

    typedef struct {
        bit               cfg;
        logic [CAP_W-1:0] val;
        bit               typed;
        evt_t             kind;
        logic [LEN_W-1:0] len;
    } dir_row_t;

    localparam int DIR_ROWS = 29;

    // Directed table: capacity writes and bytes, with the expected event typed
    // in where a single, obvious result follows.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, DELIM,        1'b1, EVT_EMPTY,   12'd0},  // delimiter right after reset
        '{1'b0, 8'h01,        1'b0, EVT_BYTE,    12'd0},  // code with just one zero
        '{1'b0, DELIM,        1'b1, EVT_GOOD,    12'd0},
        '{1'b0, 8'h03,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, 8'hFF,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, 8'h80,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, DELIM,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, CODE_RUN_LO,  1'b0, EVT_BYTE,    12'd0},  // shortest zero run
        '{1'b0, CODE_PAIR_LO, 1'b0, EVT_BYTE,    12'd0},  // zero pair, no data
        '{1'b0, DELIM,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, CODE_RUN_HI,  1'b0, EVT_BYTE,    12'd0},  // longest zero run
        '{1'b0, 8'hE2,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, 8'h7F,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, 8'h01,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, DELIM,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, CODE_FULL,    1'b0, EVT_BYTE,    12'd0},  // full block cut short
        '{1'b0, 8'h55,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, DELIM,        1'b1, EVT_BROKEN,  12'd0},
        '{1'b0, 8'hFF,        1'b0, EVT_BYTE,    12'd0},  // largest pair code
        '{1'b0, DELIM,        1'b1, EVT_BROKEN,  12'd0},
        '{1'b1, 13'd2,        1'b0, EVT_BYTE,    12'd0},  // smallest capacity that still fits a byte
        '{1'b0, 8'h02,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, 8'h41,        1'b1, EVT_OVERRUN, 12'd0},  // implicit zero does not fit
        '{1'b0, DELIM,        1'b1, EVT_EMPTY,   12'd0},
        '{1'b1, 13'd1,        1'b0, EVT_BYTE,    12'd0},  // capacity below two
        '{1'b0, 8'h05,        1'b1, EVT_OVERRUN, 12'd0},
        '{1'b0, DELIM,        1'b0, EVT_BYTE,    12'd0},
        '{1'b1, 13'd0,        1'b0, EVT_BYTE,    12'd0},
        '{1'b0, CODE_RUN_HI,  1'b0, EVT_BYTE,    12'd0}
    };

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, random phases, then drain and report.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        res_t want;
        logic [CAP_W-1:0] caps [8];
        int first;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        row_typed = 1'b0;
        row_want  = '0;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        hold_req  = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // walk the directed table under the long receiver hold-off
        hold_req = 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg) begin
                write_capacity(dir_rows[i].val);
            end else begin
                want.kind = dir_rows[i].kind;
                want.data = '0;
                want.len  = dir_rows[i].len;
                want.last = 1'b1;
                send_byte(dir_rows[i].val[BYTE_W-1:0], dir_rows[i].typed, want);
            end
        end

        // random phases, one capacity and about one frame each; the third
        // runs without idling
        caps = '{CAP_RESET, 13'd25, 13'd2, CAP_TOP, 13'd1, 13'd0, 13'd600, 13'd4096};
        caps[6] = 13'($urandom_range(3, 300));
        for (int p = 0; p < 8; p++) begin
            write_capacity(caps[p]);
            tx_quiet = (p == 2);
            rx_quiet = (p == 2);
            first = n_sent;
            while (n_sent - first < PHASE_ITEMS)
                send_frame();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // drop valid, wait for every owed result, then let the block settle
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d encoded bytes under %0d capacity writes, %0d results checked",
                 n_sent, n_caps, n_res);
        $display("Frames good %0d, empty %0d, broken %0d, overruns %0d; input stalled %0d cycles",
                 kind_cnt[EVT_GOOD], kind_cnt[EVT_EMPTY], kind_cnt[EVT_BROKEN],
                 kind_cnt[EVT_OVERRUN], n_in_stall);
        if (n_err == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
